/* hw/rtl/dhlsw_pkg.sv */
// ----------------------------------------------------------------------------
// dhlsw_pkg
// Shared types and constants for the dual-half LCD shadow writer.
// ----------------------------------------------------------------------------
package dhlsw_pkg;

    // Default geometry of the panel
    localparam int DEF_NUM_COLUMNS  = 122;
    localparam int DEF_HALF_COLUMNS = 61;
    localparam int DEF_NUM_PAGES    = 4;

    // Request opcodes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_POWER   = 2'd1;
    localparam logic [1:0] OP_TOPLINE = 2'd2;

    // Control pin codes
    localparam logic [2:0] CTRL_CMD  = 3'd4;
    localparam logic [2:0] CTRL_DATA = 3'd6;

    // Controller command bytes
    localparam logic [7:0] CMD_PAGE    = 8'hb8;
    localparam logic [7:0] CMD_TOPLINE = 8'hc0;
    localparam logic [7:0] CMD_ON      = 8'haf;
    localparam logic [7:0] CMD_OFF     = 8'hae;

    // One word on the LCD bus
    typedef struct packed {
        logic [2:0] ctrl;
        logic [7:0] data;
        logic       right;
        logic       last;
    } t_bus_word;

endpackage

/* hw/rtl/dhlsw_cmd_if.sv */
// ----------------------------------------------------------------------------
// dhlsw_cmd_if
// Request channel: valid/ready handshake with the write or command fields.
// ----------------------------------------------------------------------------
interface dhlsw_cmd_if;

    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [6:0] column_x;
    logic [1:0] page_y;
    logic [7:0] data_byte;
    logic       switch_on;
    logic [4:0] top_line;

    modport source (
        output valid, opcode, column_x, page_y, data_byte, switch_on, top_line,
        input  ready
    );

    modport sink (
        input  valid, opcode, column_x, page_y, data_byte, switch_on, top_line,
        output ready
    );

endinterface

/* hw/rtl/dhlsw_bus_if.sv */
// ----------------------------------------------------------------------------
// dhlsw_bus_if
// Bus word channel: valid/ready handshake with one strobed LCD bus word.
// ----------------------------------------------------------------------------
interface dhlsw_bus_if;

    logic       valid;
    logic       ready;
    logic [2:0] ctrl_bits;
    logic [7:0] bus_byte;
    logic       strobe_right;
    logic       last_flag;

    modport source (
        output valid, ctrl_bits, bus_byte, strobe_right, last_flag,
        input  ready
    );

    modport sink (
        input  valid, ctrl_bits, bus_byte, strobe_right, last_flag,
        output ready
    );

endinterface

/* hw/rtl/dual_half_lcd_shadow_writer.sv */
// ----------------------------------------------------------------------------
// dual_half_lcd_shadow_writer
// Write front end for a two-controller graphic LCD with a shadow RAM that
// suppresses writes of unchanged bytes.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake     | Item
//  --------+-----+---------------+------------------------------------------
//  i_cmd   | in  | valid / ready | write byte, display on/off or top line
//  o_bus   | out | valid / ready | one strobed bus word (ctrl, byte, half)
//
//  A changed byte write gives three bus words and holds the word sequencer
//  until they are taken; on/off and top-line give two; an unchanged write,
//  a bad page or an unused opcode gives none and does not wait on the sequencer.
//  The output sequencer, one word per cycle while o_bus is ready, sets the
//  sustained rate. After reset the shadow RAM is swept to zero, one entry a
//  cycle, over all NUM_COLUMNS * NUM_PAGES entries (488 by default), and
//  i_cmd.ready stays low. A stalled o_bus holds the sequencer; the next
//  request still sits in the lookup stage with its shadow byte already read.
//
module dual_half_lcd_shadow_writer #(
    parameter int NUM_COLUMNS  = dhlsw_pkg::DEF_NUM_COLUMNS,
    parameter int HALF_COLUMNS = dhlsw_pkg::DEF_HALF_COLUMNS,
    parameter int NUM_PAGES    = dhlsw_pkg::DEF_NUM_PAGES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dhlsw_cmd_if.sink    i_cmd,
    dhlsw_bus_if.source  o_bus
);

    import dhlsw_pkg::*;

    localparam int DEPTH = NUM_COLUMNS * NUM_PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------- shadow RAM ----------------
    logic [7:0]    shadow_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    // ---------------- clearing sweep ----------------
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // ---------------- request decode (stage 0) ----------------
    logic          in_take;
    logic [7:0]    x_cl;
    logic          page_ok;
    logic [AW-1:0] rd_idx;

    // ---------------- lookup stage (stage 1) ----------------
    logic          r_s1_valid;
    logic [1:0]    r_s1_op;
    logic [7:0]    r_s1_x;
    logic [1:0]    r_s1_y;
    logic          r_s1_page_ok;
    logic [AW-1:0] r_s1_idx;
    logic [7:0]    r_s1_data;
    logic          r_s1_sw;
    logic [4:0]    r_s1_line;
    logic          r_s1_fwd;
    logic [7:0]    r_s1_fwd_data;

    logic [7:0]    cur_byte;
    logic          is_write;
    logic          wr_changed;
    logic          s1_emit;
    logic          s1_adv;
    logic          s1_right;
    logic [7:0]    s1_col;
    logic [7:0]    bcast_byte;

    // ---------------- word sequencer ----------------
    t_bus_word     r_w0, r_w1, r_w2;
    logic [1:0]    r_cnt;
    t_bus_word     n_w0, n_w1, n_w2;
    logic [1:0]    n_cnt;
    logic          out_take;
    logic          q_free;

    // ---- stage 0: clamp column, form shadow address ----
    always_comb begin
        if (32'(i_cmd.column_x) > NUM_COLUMNS - 1) begin
            x_cl = 8'(NUM_COLUMNS - 1);
        end else begin
            x_cl = {1'b0, i_cmd.column_x};
        end
        page_ok = (32'(i_cmd.page_y) < NUM_PAGES);
        // bad page reads entry 0; the result is ignored anyway
        rd_idx  = page_ok ? AW'(32'(x_cl) * NUM_PAGES + 32'(i_cmd.page_y)) : '0;
    end

    // ---- stage 1: compare with shadow (forwarded if just written) ----
    always_comb begin
        cur_byte   = r_s1_fwd ? r_s1_fwd_data : r_rdata;
        is_write   = (r_s1_op == OP_WRITE) && r_s1_page_ok;
        wr_changed = is_write && (cur_byte != r_s1_data);
        s1_emit    = r_s1_valid &&
                     (wr_changed || (r_s1_op == OP_POWER) || (r_s1_op == OP_TOPLINE));
        s1_right   = (32'(r_s1_x) >= HALF_COLUMNS);
        s1_col     = s1_right ? (r_s1_x - 8'(HALF_COLUMNS)) : r_s1_x;
        if (r_s1_op == OP_POWER) begin
            bcast_byte = r_s1_sw ? CMD_ON : CMD_OFF;
        end else begin
            bcast_byte = CMD_TOPLINE | {3'b000, r_s1_line};
        end
    end

    assign out_take    = o_bus.valid && o_bus.ready;
    assign q_free      = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_take);
    assign s1_adv      = r_s1_valid && (!s1_emit || q_free);
    assign i_cmd.ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_take     = i_cmd.valid && i_cmd.ready;

    // ---- shadow write port: sweep after reset, else read-modify-write ----
    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 8'h00;
        end else begin
            mem_we    = s1_adv && wr_changed;
            mem_waddr = r_s1_idx;
            mem_wdata = r_s1_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            shadow_mem[mem_waddr] <= mem_wdata;
        end
        if (in_take) begin
            r_rdata <= shadow_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ---- lookup stage registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_op       <= i_cmd.opcode;
            r_s1_x        <= x_cl;
            r_s1_y        <= i_cmd.page_y;
            r_s1_page_ok  <= page_ok;
            r_s1_idx      <= rd_idx;
            r_s1_data     <= i_cmd.data_byte;
            r_s1_sw       <= i_cmd.switch_on;
            r_s1_line     <= i_cmd.top_line;
            // RAM read sees old data when the same entry is written this edge
            r_s1_fwd      <= mem_we && (mem_waddr == rd_idx);
            r_s1_fwd_data <= mem_wdata;
        end
    end

    // ---- word sequencer: load on free slot, else shift on take ----
    always_comb begin
        n_w0  = r_w0;
        n_w1  = r_w1;
        n_w2  = r_w2;
        n_cnt = r_cnt;
        if (s1_adv && s1_emit) begin
            if (wr_changed) begin
                n_w0  = '{ctrl: CTRL_CMD, data: CMD_PAGE | {6'b0, r_s1_y},
                           right: s1_right, last: 1'b0};
                n_w1  = '{ctrl: CTRL_CMD, data: s1_col, right: s1_right, last: 1'b0};
                n_w2  = '{ctrl: CTRL_DATA, data: r_s1_data, right: s1_right, last: 1'b1};
                n_cnt = 2'd3;
            end else begin
                n_w0  = '{ctrl: CTRL_CMD, data: bcast_byte, right: 1'b0, last: 1'b0};
                n_w1  = '{ctrl: CTRL_CMD, data: bcast_byte, right: 1'b1, last: 1'b1};
                n_cnt = 2'd2;
            end
        end else if (out_take) begin
            n_w0  = r_w1;
            n_w1  = r_w2;
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w0 <= n_w0;
        r_w1 <= n_w1;
        r_w2 <= n_w2;
    end

    assign o_bus.valid        = (r_cnt != 2'd0);
    assign o_bus.ctrl_bits    = r_w0.ctrl;
    assign o_bus.bus_byte     = r_w0.data;
    assign o_bus.strobe_right = r_w0.right;
    assign o_bus.last_flag    = r_w0.last;

endmodule
